// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define I2CMS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion violated");

// next-cycle implication
`define I2CMS_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion violated");

`endif

// ===== hdl/i2cms_pkg.sv =====
// Package for the I2C master message sequencer: sizes, codes, payload types.
// No dependencies.
package i2cms_pkg;

    localparam int MAX_MSGS = 8;
    localparam int MAX_LEN  = 64;

    localparam int CUR_W   = 4;
    localparam int CUR_MAX = (1 << CUR_W) - 1;
    localparam int MSG_AW  = (MAX_MSGS > 1) ? $clog2(MAX_MSGS) : 1;
    localparam int POS_AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int CNT_W   = $clog2(MAX_MSGS + 1);
    localparam int CMP_W   = (CNT_W > CUR_W) ? CNT_W : CUR_W;
    localparam int DESC_W  = 7 + 1 + LEN_W;
    localparam int SEND_DEPTH = MAX_MSGS * MAX_LEN;
    localparam int SEND_AW = (SEND_DEPTH > 1) ? $clog2(SEND_DEPTH) : 1;

    localparam logic [2:0] REQ_LOAD_DESC = 3'd0;
    localparam logic [2:0] REQ_LOAD_BYTE = 3'd1;
    localparam logic [2:0] REQ_START     = 3'd2;
    localparam logic [2:0] REQ_BYTE_DONE = 3'd3;
    localparam logic [2:0] REQ_COND_DONE = 3'd4;

    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_SEND    = 3'd1;
    localparam logic [2:0] ACT_STOP    = 3'd2;
    localparam logic [2:0] ACT_RESTART = 3'd3;
    localparam logic [2:0] ACT_DONE    = 3'd4;

    localparam logic [1:0] ACK_KEEP = 2'd0;
    localparam logic [1:0] ACK_ACK  = 2'd1;
    localparam logic [1:0] ACK_NACK = 2'd2;

    localparam logic [1:0] DRV_KEEP   = 2'd0;
    localparam logic [1:0] DRV_SERIAL = 2'd1;
    localparam logic [1:0] DRV_HIZ    = 2'd2;

    localparam logic [7:0] CLOCK_OUT_BYTE = 8'hff;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ADDR,
        PH_TX,
        PH_RX,
        PH_STOP,
        PH_RESTART,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [6:0]       addr;
        logic             rd;
        logic [LEN_W-1:0] len;
    } desc_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic [2:0] desc_index;
        logic [6:0] desc_addr;
        logic       desc_read;
        logic [5:0] desc_length;
        logic [5:0] byte_offset;
        logic [7:0] write_data;
        logic [3:0] msg_total;
        logic       nack_seen;
        logic [7:0] rx_data;
        logic       cond_flag;
    } req_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] tx_byte;
        logic [1:0] ack_ctrl;
        logic [1:0] line_drive;
        logic       rx_valid;
        logic [2:0] rx_msg;
        logic [5:0] rx_offset;
        logic [7:0] rx_byte;
        logic       status;
    } rsp_t;

endpackage

// ===== hdl/i2c_master_message_sequencer.sv =====
// I2C master message sequencer, top level.
// Depends on i2cms_pkg, i2cms_ram, i2cms_seq, i2cms_out_buf.
//
// Every accepted transaction (descriptor load, send-byte load, start, byte done,
// condition done) yields exactly one result, visible in the next cycle when the
// output is free. One transaction is taken per cycle while req_stall is low:
// both RAMs (8-entry descriptor table, 512-byte send store) are read every cycle
// at the address given by the next state, so their registered read is hidden; a
// write to the entry being prefetched is forwarded. An output register plus one
// skid entry decouple the two sides; req_stall rises only when both hold
// results. No clearing pass.
module i2c_master_message_sequencer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  i2cms_pkg::req_t req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output i2cms_pkg::rsp_t rsp
);

    logic                           accept;
    logic                           full;
    i2cms_pkg::rsp_t                result;
    logic                           desc_we;
    logic [i2cms_pkg::MSG_AW-1:0]   desc_wr_addr;
    logic [i2cms_pkg::DESC_W-1:0]   desc_wr_data;
    logic [i2cms_pkg::MSG_AW-1:0]   desc_rd_addr;
    logic [i2cms_pkg::DESC_W-1:0]   desc_rd_data;
    logic                           send_we;
    logic [i2cms_pkg::SEND_AW-1:0]  send_wr_addr;
    logic [7:0]                     send_wr_data;
    logic [i2cms_pkg::SEND_AW-1:0]  send_rd_addr;
    logic [7:0]                     send_rd_data;

    assign req_stall = full;
    assign accept    = req_valid && !full;

    i2cms_ram #(
        .WIDTH (i2cms_pkg::DESC_W),
        .DEPTH (i2cms_pkg::MAX_MSGS)
    ) u_desc_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (desc_we),
        .wr_addr (desc_wr_addr),
        .wr_data (desc_wr_data),
        .rd_addr (desc_rd_addr),
        .rd_data (desc_rd_data)
    );

    i2cms_ram #(
        .WIDTH (8),
        .DEPTH (i2cms_pkg::SEND_DEPTH)
    ) u_send_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (send_we),
        .wr_addr (send_wr_addr),
        .wr_data (send_wr_data),
        .rd_addr (send_rd_addr),
        .rd_data (send_rd_data)
    );

    i2cms_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .req          (req),
        .desc_rd_data (desc_rd_data),
        .send_rd_data (send_rd_data),
        .desc_we      (desc_we),
        .desc_wr_addr (desc_wr_addr),
        .desc_wr_data (desc_wr_data),
        .desc_rd_addr (desc_rd_addr),
        .send_we      (send_we),
        .send_wr_addr (send_wr_addr),
        .send_wr_data (send_wr_data),
        .send_rd_addr (send_rd_addr),
        .rsp          (result)
    );

    i2cms_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (result),
        .full      (full),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

// ===== hdl/i2cms_ram.sv =====
// Simple dual-port RAM, registered read, write-to-read forwarding.
// No dependencies.
module i2cms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_q_reg;
    logic [WIDTH-1:0] fwd_data_reg;
    logic             fwd_hit_reg;
    logic             fwd_hit_next;

    assign fwd_hit_next = wr_en && (wr_addr == rd_addr);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_q_reg     <= mem_reg[rd_addr];
        fwd_data_reg <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            fwd_hit_reg <= fwd_hit_next;
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : rd_q_reg;

endmodule

// ===== hdl/i2cms_seq.sv =====
// Sequencer control: phase and position registers, per-transaction update logic,
// memory write and prefetch addressing. Depends on i2cms_pkg.
module i2cms_seq (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  i2cms_pkg::req_t                req,
    input  logic [i2cms_pkg::DESC_W-1:0]   desc_rd_data,
    input  logic [7:0]                     send_rd_data,
    output logic                           desc_we,
    output logic [i2cms_pkg::MSG_AW-1:0]   desc_wr_addr,
    output logic [i2cms_pkg::DESC_W-1:0]   desc_wr_data,
    output logic [i2cms_pkg::MSG_AW-1:0]   desc_rd_addr,
    output logic                           send_we,
    output logic [i2cms_pkg::SEND_AW-1:0]  send_wr_addr,
    output logic [7:0]                     send_wr_data,
    output logic [i2cms_pkg::SEND_AW-1:0]  send_rd_addr,
    output i2cms_pkg::rsp_t                rsp
);

    i2cms_pkg::phase_t              phase_reg, phase_next;
    logic [i2cms_pkg::CUR_W-1:0]    cur_reg, cur_next;
    logic [i2cms_pkg::LEN_W-1:0]    bpos_reg, bpos_next;
    logic                           reading_reg, reading_next;
    logic                           dummy_reg, dummy_next;
    logic                           error_reg, error_next;
    logic [i2cms_pkg::CNT_W-1:0]    count_reg, count_next;

    i2cms_pkg::desc_t               desc;
    i2cms_pkg::desc_t               desc_new;
    logic [i2cms_pkg::LEN_W-1:0]    bp_inc;
    logic [i2cms_pkg::LEN_W-1:0]    bp_rx;
    logic [i2cms_pkg::CUR_W-1:0]    cur_adv;
    logic                           adv_stop;
    logic                           do_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= i2cms_pkg::PH_IDLE;
            cur_reg     <= '0;
            bpos_reg    <= '0;
            reading_reg <= 1'b0;
            dummy_reg   <= 1'b0;
            error_reg   <= 1'b0;
            count_reg   <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            cur_reg     <= cur_next;
            bpos_reg    <= bpos_next;
            reading_reg <= reading_next;
            dummy_reg   <= dummy_next;
            error_reg   <= error_next;
            count_reg   <= count_next;
        end
    end

    // descriptor of the current message; slots past the table read as zero
    always_comb
    begin
        desc = i2cms_pkg::desc_t'(desc_rd_data);
        if (phase_reg != i2cms_pkg::PH_IDLE && phase_reg != i2cms_pkg::PH_DONE &&
            int'(cur_reg) >= i2cms_pkg::MAX_MSGS)
        begin
            desc = '0;
        end
    end

    assign bp_inc  = bpos_reg + 1'b1;
    assign bp_rx   = (bpos_reg < desc.len) ? bp_inc : bpos_reg;
    assign cur_adv = (int'(cur_reg) < i2cms_pkg::CUR_MAX) ? cur_reg + 1'b1 : cur_reg;
    assign adv_stop = i2cms_pkg::CMP_W'(cur_adv) >= i2cms_pkg::CMP_W'(count_reg);

    always_comb
    begin
        desc_new.addr = req.desc_addr;
        desc_new.rd   = req.desc_read;
        desc_new.len  = (int'(req.desc_length) > i2cms_pkg::MAX_LEN) ?
                        i2cms_pkg::LEN_W'(i2cms_pkg::MAX_LEN) :
                        i2cms_pkg::LEN_W'(req.desc_length);
    end

    assign desc_wr_addr = i2cms_pkg::MSG_AW'(req.desc_index);
    assign desc_wr_data = desc_new;
    assign send_wr_data = req.write_data;
    assign send_wr_addr = i2cms_pkg::SEND_AW'(
        int'(i2cms_pkg::MSG_AW'(req.desc_index)) * i2cms_pkg::MAX_LEN +
        int'(i2cms_pkg::POS_AW'(req.byte_offset)));

    always_comb
    begin
        phase_next   = phase_reg;
        cur_next     = cur_reg;
        bpos_next    = bpos_reg;
        reading_next = reading_reg;
        dummy_next   = dummy_reg;
        error_next   = error_reg;
        count_next   = count_reg;
        rsp          = '0;
        desc_we      = 1'b0;
        send_we      = 1'b0;
        do_adv       = 1'b0;

        if (accept)
        begin
            unique case (req.req_type)
                i2cms_pkg::REQ_LOAD_DESC:
                begin
                    desc_we = int'(req.desc_index) < i2cms_pkg::MAX_MSGS;
                end
                i2cms_pkg::REQ_LOAD_BYTE:
                begin
                    send_we = (int'(req.desc_index) < i2cms_pkg::MAX_MSGS) &&
                              (int'(req.byte_offset) < i2cms_pkg::MAX_LEN);
                end
                i2cms_pkg::REQ_START:
                begin
                    if (phase_reg == i2cms_pkg::PH_IDLE || phase_reg == i2cms_pkg::PH_DONE)
                    begin
                        count_next   = (int'(req.msg_total) > i2cms_pkg::MAX_MSGS) ?
                                       i2cms_pkg::CNT_W'(i2cms_pkg::MAX_MSGS) :
                                       i2cms_pkg::CNT_W'(req.msg_total);
                        cur_next     = '0;
                        bpos_next    = '0;
                        error_next   = 1'b0;
                        reading_next = desc.rd;
                        dummy_next   = desc.rd;
                        if (req.msg_total == '0)
                        begin
                            phase_next = i2cms_pkg::PH_DONE;
                            rsp.action = i2cms_pkg::ACT_DONE;
                        end
                        else
                        begin
                            phase_next = i2cms_pkg::PH_ADDR;
                        end
                    end
                end
                i2cms_pkg::REQ_BYTE_DONE:
                begin
                    if (phase_reg != i2cms_pkg::PH_IDLE && phase_reg != i2cms_pkg::PH_DONE)
                    begin
                        if (req.nack_seen)
                        begin
                            if (!reading_reg || dummy_reg)
                            begin
                                error_next = 1'b1;
                                phase_next = i2cms_pkg::PH_STOP;
                                rsp.action = i2cms_pkg::ACT_STOP;
                            end
                            else
                            begin
                                if (bpos_reg < desc.len)
                                begin
                                    rsp.rx_valid  = 1'b1;
                                    rsp.rx_msg    = 3'(cur_reg);
                                    rsp.rx_offset = 6'(bpos_reg);
                                    rsp.rx_byte   = req.rx_data;
                                end
                                bpos_next = bp_rx;
                                do_adv    = 1'b1;
                            end
                        end
                        else
                        begin
                            unique case (phase_reg)
                                i2cms_pkg::PH_ADDR, i2cms_pkg::PH_TX:
                                begin
                                    if (phase_reg == i2cms_pkg::PH_ADDR && reading_reg)
                                    begin
                                        rsp.line_drive = i2cms_pkg::DRV_SERIAL;
                                        phase_next     = i2cms_pkg::PH_RX;
                                        rsp.ack_ctrl   = (desc.len > 1) ?
                                                         i2cms_pkg::ACK_ACK :
                                                         i2cms_pkg::ACK_NACK;
                                        dummy_next     = 1'b0;
                                        rsp.action     = i2cms_pkg::ACT_SEND;
                                        rsp.tx_byte    = i2cms_pkg::CLOCK_OUT_BYTE;
                                    end
                                    else
                                    begin
                                        phase_next = i2cms_pkg::PH_TX;
                                        if (bpos_reg < desc.len)
                                        begin
                                            rsp.action  = i2cms_pkg::ACT_SEND;
                                            rsp.tx_byte = send_rd_data;
                                            bpos_next   = bp_inc;
                                        end
                                        else
                                        begin
                                            do_adv = 1'b1;
                                        end
                                    end
                                end
                                i2cms_pkg::PH_RX:
                                begin
                                    if (bpos_reg < desc.len)
                                    begin
                                        rsp.rx_valid  = 1'b1;
                                        rsp.rx_msg    = 3'(cur_reg);
                                        rsp.rx_offset = 6'(bpos_reg);
                                        rsp.rx_byte   = req.rx_data;
                                    end
                                    bpos_next = bp_rx;
                                    if (bp_rx >= desc.len)
                                    begin
                                        do_adv = 1'b1;
                                    end
                                    else
                                    begin
                                        rsp.ack_ctrl = (bp_rx + 1'b1 == desc.len) ?
                                                       i2cms_pkg::ACK_NACK :
                                                       i2cms_pkg::ACK_ACK;
                                        rsp.action   = i2cms_pkg::ACT_SEND;
                                        rsp.tx_byte  = i2cms_pkg::CLOCK_OUT_BYTE;
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                    end
                end
                i2cms_pkg::REQ_COND_DONE:
                begin
                    if (req.cond_flag)
                    begin
                        unique case (phase_reg)
                            i2cms_pkg::PH_RESTART:
                            begin
                                reading_next   = desc.rd;
                                dummy_next     = desc.rd;
                                phase_next     = i2cms_pkg::PH_ADDR;
                                rsp.line_drive = i2cms_pkg::DRV_SERIAL;
                                rsp.action     = i2cms_pkg::ACT_SEND;
                                rsp.tx_byte    = {desc.addr, desc.rd};
                            end
                            i2cms_pkg::PH_STOP:
                            begin
                                rsp.line_drive = i2cms_pkg::DRV_HIZ;
                                phase_next     = i2cms_pkg::PH_DONE;
                                rsp.action     = i2cms_pkg::ACT_DONE;
                                rsp.status     = error_reg;
                            end
                            i2cms_pkg::PH_ADDR:
                            begin
                                rsp.line_drive = i2cms_pkg::DRV_SERIAL;
                                rsp.action     = i2cms_pkg::ACT_SEND;
                                rsp.tx_byte    = {desc.addr, reading_reg};
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                default:
                begin
                end
            endcase
        end

        // next message: restart, or stop past the last one
        if (do_adv)
        begin
            cur_next = cur_adv;
            if (adv_stop)
            begin
                phase_next = i2cms_pkg::PH_STOP;
                rsp.action = i2cms_pkg::ACT_STOP;
            end
            else
            begin
                bpos_next    = '0;
                reading_next = 1'b0;
                dummy_next   = 1'b0;
                phase_next   = i2cms_pkg::PH_RESTART;
                rsp.action   = i2cms_pkg::ACT_RESTART;
            end
        end
    end

    // prefetch for the next transaction, addressed by the next state
    always_comb
    begin
        if (phase_next == i2cms_pkg::PH_IDLE || phase_next == i2cms_pkg::PH_DONE)
        begin
            desc_rd_addr = '0;
        end
        else
        begin
            desc_rd_addr = i2cms_pkg::MSG_AW'(cur_next);
        end
        send_rd_addr = i2cms_pkg::SEND_AW'(
            int'(i2cms_pkg::MSG_AW'(cur_next)) * i2cms_pkg::MAX_LEN +
            int'(i2cms_pkg::POS_AW'(bpos_next)));
    end

endmodule

// ===== hdl/i2cms_out_buf.sv =====
// Result output register with one skid entry.
// Depends on i2cms_pkg.
module i2cms_out_buf (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  i2cms_pkg::rsp_t push_data,
    output logic            full,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output i2cms_pkg::rsp_t rsp
);

    logic            out_valid_reg, out_valid_next;
    logic            skid_valid_reg, skid_valid_next;
    i2cms_pkg::rsp_t out_data_reg, out_data_next;
    i2cms_pkg::rsp_t skid_data_reg, skid_data_next;
    logic            fire;

    assign fire = out_valid_reg && !rsp_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (push)
        begin
            if (out_valid_reg && !fire)
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
            else
            begin
                out_valid_next = 1'b1;
                out_data_next  = push_data;
            end
        end
        else if (fire)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

endmodule

// ===== hdl/i2cms_checker.sv =====
// Port-level checker for the I2C master message sequencer, with its bind.
// Depends on i2cms_pkg and assert_macros.svh.
`include "assert_macros.svh"

module i2cms_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            req_valid,
    input logic            req_stall,
    input i2cms_pkg::req_t req,
    input logic            rsp_valid,
    input logic            rsp_stall,
    input i2cms_pkg::rsp_t rsp
);

    // stalled result holds
    `I2CMS_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

    // input stalls only with a result waiting
    `I2CMS_ASSERT_IMP(a_stall_has_rsp, clk, rst_n, req_stall, rsp_valid)

    // a taken result frees the input
    `I2CMS_ASSERT_NXT(a_stall_release, clk, rst_n, rsp_valid && !rsp_stall, !req_stall)

    // an accepted transaction leaves a result valid next cycle
    `I2CMS_ASSERT_NXT(a_one_result, clk, rst_n, req_valid && !req_stall, rsp_valid)

endmodule

bind i2c_master_message_sequencer i2cms_checker u_checker (.*);

// ===== tb/sv/tb_i2c_master_message_sequencer.sv =====
// Testbench for i2c_master_message_sequencer: a directed table, then random
// multi-message transfers checked against an in-bench sequencer model.
// Depends on i2cms_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb;
    import i2cms_pkg::*;

    localparam logic [2:0] REQ_UNUSED = 3'd7;
    localparam int ITEM_BUDGET = 1350;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam rsp_t NOTHING = '0;

    typedef struct packed {
        req_t rq;
        logic chk;
        rsp_t want;
    } dir_row_t;

    localparam dir_row_t DIRECTED [28] = '{
        '{rq: '{req_type: REQ_BYTE_DONE, nack_seen: 1'b1, default: '0},
            chk: 1'b1, want: NOTHING},
        '{rq: '{req_type: REQ_COND_DONE, cond_flag: 1'b1, default: '0},
            chk: 1'b1, want: NOTHING},
        '{rq: '{req_type: REQ_UNUSED, default: '1}, chk: 1'b1, want: NOTHING},
        '{rq: '{req_type: REQ_LOAD_DESC, desc_index: 3'd0, desc_addr: 7'h7f,
            desc_length: 6'd2, default: '0}, chk: 1'b1, want: NOTHING},
        '{rq: '{req_type: REQ_LOAD_DESC, desc_index: 3'd1, desc_read: 1'b1,
            desc_length: 6'd3, default: '0}, chk: 1'b1, want: NOTHING},
        '{rq: '{req_type: REQ_LOAD_DESC, desc_index: 3'd2, desc_addr: 7'h55,
            desc_read: 1'b1, desc_length: 6'd1, default: '0}, chk: 1'b1, want: NOTHING},
        '{rq: '{req_type: REQ_LOAD_DESC, desc_index: 3'd7, desc_addr: 7'h2a,
            desc_length: 6'd63, default: '0}, chk: 1'b1, want: NOTHING},
        '{rq: '{req_type: REQ_LOAD_BYTE, write_data: 8'hff, default: '0},
            chk: 1'b1, want: NOTHING},
        '{rq: '{req_type: REQ_LOAD_BYTE, byte_offset: 6'd1, default: '0},
            chk: 1'b1, want: NOTHING},
        '{rq: '{req_type: REQ_LOAD_BYTE, desc_index: 3'd7, byte_offset: 6'd63,
            write_data: 8'ha5, default: '0}, chk: 1'b1, want: NOTHING},
        '{rq: '{req_type: REQ_START, msg_total: 4'd3, default: '0},
            chk: 1'b1, want: NOTHING},
        '{rq: '{req_type: REQ_COND_DONE, cond_flag: 1'b1, default: '0}, chk: 1'b1,
            want: '{action: ACT_SEND, tx_byte: 8'hfe, line_drive: DRV_SERIAL, default: '0}},
        '{rq: '{req_type: REQ_BYTE_DONE, default: '0}, chk: 1'b0, want: NOTHING},
        '{rq: '{req_type: REQ_BYTE_DONE, default: '0}, chk: 1'b0, want: NOTHING},
        '{rq: '{req_type: REQ_BYTE_DONE, default: '0}, chk: 1'b0, want: NOTHING},
        '{rq: '{req_type: REQ_START, msg_total: 4'd8, default: '0},
            chk: 1'b1, want: NOTHING},
        '{rq: '{req_type: REQ_COND_DONE, default: '0}, chk: 1'b1, want: NOTHING},
        '{rq: '{req_type: REQ_COND_DONE, cond_flag: 1'b1, default: '0},
            chk: 1'b0, want: NOTHING},
        '{rq: '{req_type: REQ_BYTE_DONE, default: '0}, chk: 1'b0, want: NOTHING},
        '{rq: '{req_type: REQ_BYTE_DONE, rx_data: 8'h12, default: '0},
            chk: 1'b0, want: NOTHING},
        '{rq: '{req_type: REQ_BYTE_DONE, rx_data: 8'h34, default: '0},
            chk: 1'b0, want: NOTHING},
        '{rq: '{req_type: REQ_BYTE_DONE, nack_seen: 1'b1, rx_data: 8'h56, default: '0},
            chk: 1'b0, want: NOTHING},
        '{rq: '{req_type: REQ_COND_DONE, cond_flag: 1'b1, default: '0},
            chk: 1'b0, want: NOTHING},
        '{rq: '{req_type: REQ_BYTE_DONE, nack_seen: 1'b1, default: '0},
            chk: 1'b1, want: '{action: ACT_STOP, default: '0}},
        '{rq: '{req_type: REQ_BYTE_DONE, nack_seen: 1'b1, default: '0},
            chk: 1'b1, want: '{action: ACT_STOP, default: '0}},
        '{rq: '{req_type: REQ_BYTE_DONE, default: '0}, chk: 1'b1, want: NOTHING},
        '{rq: '{req_type: REQ_COND_DONE, cond_flag: 1'b1, default: '0}, chk: 1'b1,
            want: '{action: ACT_DONE, line_drive: DRV_HIZ, status: 1'b1, default: '0}},
        '{rq: '{req_type: REQ_START, default: '0}, chk: 1'b1,
            want: '{action: ACT_DONE, default: '0}}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // sequencer model state
    phase_t ph = PH_IDLE;
    logic [3:0] cur = '0;
    logic [6:0] pos = '0;
    logic rdg = 1'b0;
    logic dummy = 1'b0;
    logic err_mark = 1'b0;
    logic [3:0] msg_limit = '0;
    desc_t desc_tab [MAX_MSGS];
    logic [7:0] send_mem [SEND_DEPTH];
    bit byte_loaded [SEND_DEPTH];

    rsp_t expected_q [$];
    logic [2:0] last_act = ACT_NONE;
    int n_sent = 0;
    int n_results = 0;
    int n_errors = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    i2c_master_message_sequencer u_top (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic [LEN_W-1:0] msg_len(logic [3:0] m);
        return (m < MAX_MSGS) ? desc_tab[m[2:0]].len : '0;
    endfunction

    function automatic logic msg_rd(logic [3:0] m);
        return (m < MAX_MSGS) ? desc_tab[m[2:0]].rd : 1'b0;
    endfunction

    function automatic logic [6:0] msg_addr(logic [3:0] m);
        return (m < MAX_MSGS) ? desc_tab[m[2:0]].addr : 7'd0;
    endfunction

    function automatic logic [2:0] next_message();
        if (cur < 4'd15)
            cur = cur + 1'b1;
        if (cur >= msg_limit)
        begin
            ph = PH_STOP;
            return ACT_STOP;
        end
        pos = '0;
        rdg = msg_rd(cur);
        dummy = rdg;
        ph = PH_RESTART;
        return ACT_RESTART;
    endfunction

    function automatic void take_byte(inout rsp_t o, input logic [7:0] d);
        o.rx_valid = 1'b1;
        o.rx_msg = cur[2:0];
        o.rx_offset = pos[5:0];
        o.rx_byte = d;
        pos = pos + 1'b1;
    endfunction

    function automatic void send_next(inout rsp_t o);
        if (pos < msg_len(cur))
        begin
            o.action = ACT_SEND;
            o.tx_byte = send_mem[{cur[2:0], pos[5:0]}];
            pos = pos + 1'b1;
        end
        else
            o.action = next_message();
    endfunction

    function automatic rsp_t sequence_step(req_t r);
        rsp_t o;
        logic [LEN_W-1:0] mlen;
        o = '0;
        mlen = msg_len(cur);
        case (r.req_type)
            REQ_LOAD_DESC:
                desc_tab[r.desc_index] = '{addr: r.desc_addr, rd: r.desc_read,
                                           len: LEN_W'(r.desc_length)};
            REQ_LOAD_BYTE:
            begin
                send_mem[{r.desc_index, r.byte_offset}] = r.write_data;
                byte_loaded[{r.desc_index, r.byte_offset}] = 1'b1;
            end
            REQ_START:
                if (ph == PH_IDLE || ph == PH_DONE)
                begin
                    msg_limit = (r.msg_total > MAX_MSGS) ? 4'(MAX_MSGS) : r.msg_total;
                    cur = '0;
                    pos = '0;
                    err_mark = 1'b0;
                    rdg = desc_tab[0].rd;
                    dummy = rdg;
                    if (msg_limit == 0)
                    begin
                        ph = PH_DONE;
                        o.action = ACT_DONE;
                    end
                    else
                        ph = PH_ADDR;
                end
            REQ_BYTE_DONE:
                if (ph != PH_IDLE && ph != PH_DONE)
                begin
                    if (r.nack_seen)
                    begin
                        if (!rdg || dummy)
                        begin
                            err_mark = 1'b1;
                            ph = PH_STOP;
                            o.action = ACT_STOP;
                        end
                        else
                        begin
                            if (pos < mlen)
                                take_byte(o, r.rx_data);
                            o.action = next_message();
                        end
                    end
                    else if (ph == PH_ADDR)
                    begin
                        if (rdg)
                        begin
                            ph = PH_RX;
                            dummy = 1'b0;
                            o.line_drive = DRV_SERIAL;
                            o.ack_ctrl = (mlen > 1) ? ACK_ACK : ACK_NACK;
                            o.action = ACT_SEND;
                            o.tx_byte = CLOCK_OUT_BYTE;
                        end
                        else
                        begin
                            ph = PH_TX;
                            send_next(o);
                        end
                    end
                    else if (ph == PH_TX)
                        send_next(o);
                    else if (ph == PH_RX)
                    begin
                        if (pos < mlen)
                            take_byte(o, r.rx_data);
                        if (pos >= mlen)
                            o.action = next_message();
                        else
                        begin
                            o.ack_ctrl = (mlen - pos == 1) ? ACK_NACK : ACK_ACK;
                            o.action = ACT_SEND;
                            o.tx_byte = CLOCK_OUT_BYTE;
                        end
                    end
                end
            REQ_COND_DONE:
                if (r.cond_flag)
                begin
                    if (ph == PH_RESTART || ph == PH_ADDR)
                    begin
                        if (ph == PH_RESTART)
                        begin
                            rdg = msg_rd(cur);
                            dummy = rdg;
                            ph = PH_ADDR;
                        end
                        o.line_drive = DRV_SERIAL;
                        o.action = ACT_SEND;
                        o.tx_byte = {msg_addr(cur), rdg};
                    end
                    else if (ph == PH_STOP)
                    begin
                        ph = PH_DONE;
                        o.line_drive = DRV_HIZ;
                        o.action = ACT_DONE;
                        o.status = err_mark;
                    end
                end
            default:
                ;
        endcase
        return o;
    endfunction

    function automatic req_t rand_req();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return bits[$bits(req_t)-1:0];
    endfunction

    task automatic offer(input req_t item, input logic chk = 1'b0, input rsp_t want = '0);
        rsp_t p;
        req <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        p = sequence_step(item);
        expected_q.push_back(chk ? want : p);
        if (p.action != ACT_NONE)
            last_act = p.action;
        if (item.req_type <= REQ_COND_DONE)
            n_sent++;
        if ((n_sent < 500 || n_sent > 800) && $urandom_range(99) < 8)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 3))
                @(posedge clk);
        end
    endtask

    // keep the block from ever sending a byte that was never loaded
    task automatic cover_send_byte();
        req_t it;
        if ((ph == PH_ADDR || ph == PH_TX) && !rdg && cur < MAX_MSGS
            && pos < msg_len(cur) && !byte_loaded[{cur[2:0], pos[5:0]}])
        begin
            it = rand_req();
            it.req_type = REQ_LOAD_BYTE;
            it.desc_index = cur[2:0];
            it.byte_offset = pos[5:0];
            offer(it);
        end
    endtask

    task automatic run_transfer();
        req_t it;
        req_t bt;
        int n;
        int msgs;
        int len;
        int guard;
        int pick;
        pick = $urandom_range(99);
        if (pick < 4)
            n = 0;
        else if (pick < 10)
            n = $urandom_range(9, 15);
        else if (pick < 30)
            n = $urandom_range(5, 8);
        else
            n = $urandom_range(1, 4);
        msgs = (n > MAX_MSGS) ? MAX_MSGS : n;
        for (int s = 0; s < msgs; s++)
        begin
            it = rand_req();
            it.req_type = REQ_LOAD_DESC;
            it.desc_index = 3'(s);
            len = ($urandom_range(19) == 0) ? $urandom_range(63) : $urandom_range(4);
            it.desc_length = 6'(len);
            offer(it);
            if (!it.desc_read)
            begin
                for (int b = 0; b < len; b++)
                begin
                    bt = rand_req();
                    bt.req_type = REQ_LOAD_BYTE;
                    bt.desc_index = 3'(s);
                    bt.byte_offset = 6'(b);
                    offer(bt);
                end
            end
        end
        it = rand_req();
        it.req_type = REQ_START;
        it.msg_total = 4'(n);
        offer(it);
        guard = 0;
        while (ph != PH_DONE && ph != PH_IDLE && guard < 500)
        begin
            guard++;
            it = rand_req();
            if ($urandom_range(99) >= 8)
            begin
                if (last_act == ACT_SEND)
                begin
                    it.req_type = REQ_BYTE_DONE;
                    it.nack_seen = ($urandom_range(99) < ((ph == PH_RX) ? 20 : 3));
                end
                else
                begin
                    it.req_type = REQ_COND_DONE;
                    it.cond_flag = ($urandom_range(19) != 0);
                end
            end
            if (it.req_type == REQ_BYTE_DONE)
                cover_send_byte();
            offer(it);
        end
    endtask

    task automatic field_check(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            n_errors++;
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        end
    endtask

    task automatic check_result(input rsp_t got);
        rsp_t want;
        n_results++;
        if (expected_q.size() == 0)
        begin
            n_errors++;
            $display("%0t: result expected none got %h", $time, got);
        end
        else
        begin
            want = expected_q.pop_front();
            field_check("action", 8'(want.action), 8'(got.action));
            field_check("tx_byte", want.tx_byte, got.tx_byte);
            field_check("ack_ctrl", 8'(want.ack_ctrl), 8'(got.ack_ctrl));
            field_check("line_drive", 8'(want.line_drive), 8'(got.line_drive));
            field_check("rx_valid", 8'(want.rx_valid), 8'(got.rx_valid));
            field_check("rx_msg", 8'(want.rx_msg), 8'(got.rx_msg));
            field_check("rx_offset", 8'(want.rx_offset), 8'(got.rx_offset));
            field_check("rx_byte", want.rx_byte, got.rx_byte);
            field_check("status", 8'(want.status), 8'(got.status));
        end
    endtask

    // result side: check, random stall, one long hold-off to back up the input
    always @(posedge clk)
    begin
        if (rsp_valid && !rsp_stall)
            check_result(rsp);
        if (hold_left == 0 && !hold_done && n_results >= 300)
        begin
            hold_done = 1'b1;
            hold_left = 150;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= (n_results < 600 || n_results > 900) && ($urandom_range(99) < 14);
    end

    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT)
                break;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < $size(DIRECTED); i++)
            offer(DIRECTED[i].rq, DIRECTED[i].chk, DIRECTED[i].want);
        for (int s = 0; s < MAX_MSGS; s++)
        begin
            req_t it;
            it = rand_req();
            it.req_type = REQ_LOAD_DESC;
            it.desc_index = 3'(s);
            it.desc_length = 6'($urandom_range(4));
            offer(it);
        end
        while (n_sent < ITEM_BUDGET)
            run_transfer();
        req_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (10)
            @(posedge clk);
        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/i2cms_pkg.sv
hdl/i2cms_ram.sv
hdl/i2cms_seq.sv
hdl/i2cms_out_buf.sv
hdl/i2c_master_message_sequencer.sv
hdl/i2cms_checker.sv
tb/sv/tb_i2c_master_message_sequencer.sv
